[design/qrspf_pkg.sv]
// Shared types, widths and helpers for the QRS pre-processing filter chain.
// Used by qrspf_bandpass, qrspf_energy and the top level; depends on nothing.
package qrspf_pkg;

  localparam int SampleW = 16;
  localparam int DataW   = 32;

  // Raw sample history and the two taps that feed the low-pass FIR part.
  localparam int SampleTaps = 12;
  localparam int LpTapMid   = 5;
  localparam int LpTapEnd   = 11;

  // Low-pass history memory and the taps that the high-pass reads from it.
  localparam int LowDepth   = 32;
  localparam int LowAw      = $clog2(LowDepth);
  localparam int HpTapNear  = 15;
  localparam int HpTapFar   = LowDepth - 1;

  // High-pass history used by the five-point derivative.
  localparam int HighTaps   = 4;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [DataW-1:0]   word_t;

  // Band-pass stage output handed to the energy stage.
  typedef struct packed {
    logic  valid;
    word_t lp;
    word_t hp;
  } bp_out_t;

  // One finished result, ahead of the output register.
  typedef struct packed {
    logic  valid;
    word_t integ;
    word_t lp;
    word_t hp;
    word_t der;
    word_t sq;
  } result_t;

  // Signed division by 32, truncating toward zero.
  function automatic word_t div32(word_t v);
    word_t bias;
    bias = v[DataW-1] ? word_t'(31) : '0;
    return (v + bias) >>> 5;
  endfunction

  // Signed division by 8, truncating toward zero.
  function automatic word_t div8(word_t v);
    word_t bias;
    bias = v[DataW-1] ? word_t'(7) : '0;
    return (v + bias) >>> 3;
  endfunction

endpackage

[design/qrs_preprocess_filter_chain.sv]
// QRS pre-processing filter chain, top level: stream ports and output register.
// Instantiates qrspf_bandpass and qrspf_energy; depends on qrspf_pkg.
//
// Usage: one signed 16-bit ECG sample enters per transfer on the s_axis
// channel. For each sample one result leaves on the m_axis channel, in order:
// the moving-window integrator value and the low-pass, high-pass, derivative
// and squared values of that sample, each 32 bits signed with wrap-around.
// Each sample passes through six pipeline registers, R1 to R6, the first of
// which loads at the edge at which the sample is taken, and then through the
// output register. Throughput: one sample per cycle while m_axis_tready is
// high. The low-pass history memory and the window memory each take one write
// and their reads every cycle, and the filter feedback loops close inside
// single pipeline stages.
// Reset: all filter histories, the window sum and the memory fill counters
// clear, so the first samples see zero history; the block can take a sample in
// the first cycle after reset. Memory contents are not cleared; unwritten
// entries are masked by the fill counters.
// Stall: while a result waits on the output with m_axis_tready low, the whole
// pipeline holds and s_axis_tready is low; no result is lost or repeated.
module qrs_preprocess_filter_chain #(
  parameter int WINDOW = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // [15:0] sample
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata   // [31:0] integrated, [63:32] lowpass_value,
                                      // [95:64] highpass_value,
                                      // [127:96] derivative_value,
                                      // [159:128] squared_value
);

  logic               adv;
  logic               out_valid_q;
  qrspf_pkg::bp_out_t bp_stage;
  qrspf_pkg::result_t res;
  qrspf_pkg::word_t   out_integ_q, out_lp_q, out_hp_q, out_der_q, out_sq_q;

  // Everything moves unless a result sits on the output and is not taken.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  qrspf_bandpass u_bandpass (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid),
    .sample_i   (qrspf_pkg::sample_t'(s_axis_tdata)),
    .stage_o    (bp_stage)
  );

  qrspf_energy #(
    .WINDOW (WINDOW)
  ) u_energy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .bp_i   (bp_stage),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_integ_q <= res.integ;
      out_lp_q    <= res.lp;
      out_hp_q    <= res.hp;
      out_der_q   <= res.der;
      out_sq_q    <= res.sq;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_sq_q, out_der_q, out_hp_q, out_lp_q, out_integ_q};

endmodule

[design/qrspf_bandpass.sv]
// Low-pass and high-pass recursive filters of the QRS pre-processing chain.
// Holds the sample shift line, the low-pass history memory and the filter
// feedback registers. Depends on qrspf_pkg.
module qrspf_bandpass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  qrspf_pkg::sample_t sample_i,
  output qrspf_pkg::bp_out_t stage_o
);

  localparam int LowCntW = qrspf_pkg::LowAw + 1;

  qrspf_pkg::sample_t line_q [qrspf_pkg::SampleTaps];
  qrspf_pkg::word_t   fir_d;

  logic               r1_valid_q;
  qrspf_pkg::word_t   r1_fir_q;

  qrspf_pkg::word_t   lp_d, lp1_q, lp2_q;
  logic               r2_valid_q;
  qrspf_pkg::word_t   r2_lp_q;

  qrspf_pkg::word_t   lp_mem [qrspf_pkg::LowDepth];
  logic [qrspf_pkg::LowAw-1:0] wptr_q, near_addr;
  logic [LowCntW-1:0] cnt_q;
  logic               lp_wr;
  qrspf_pkg::word_t   near_rd_q, far_rd_q;
  logic               near_ok_q, far_ok_q;
  qrspf_pkg::word_t   tap_near, tap_far, tap_next_q;

  qrspf_pkg::word_t   hp_d, hp1_q;
  logic               r3_valid_q;
  qrspf_pkg::word_t   r3_lp_q, r3_hp_q;

  // Low-pass FIR part on the raw samples.
  assign fir_d = qrspf_pkg::word_t'(sample_i)
               - (qrspf_pkg::word_t'(line_q[qrspf_pkg::LpTapMid]) <<< 1)
               + qrspf_pkg::word_t'(line_q[qrspf_pkg::LpTapEnd]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qrspf_pkg::SampleTaps; i++) begin
        line_q[i] <= '0;
      end
    end else if (adv_i && in_valid_i) begin
      line_q[0] <= sample_i;
      for (int i = 1; i < qrspf_pkg::SampleTaps; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  // Low-pass recursion; the two previous outputs stay in registers.
  assign lp_d  = (lp1_q <<< 1) - lp2_q + qrspf_pkg::div32(r1_fir_q);
  assign lp_wr = adv_i && r1_valid_q;

  // The item moving into R2 writes its low-pass value at wptr_q and reads the
  // entries 16 and 32 items back; the far one shares the write address, so the
  // read-first memory returns the old value.
  assign near_addr = wptr_q - qrspf_pkg::LowAw'(qrspf_pkg::HpTapNear + 1);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      near_rd_q <= lp_mem[near_addr];
      far_rd_q  <= lp_mem[wptr_q];
    end
    if (lp_wr) begin
      lp_mem[wptr_q] <= lp_d;
    end
  end

  // Entries not yet written since reset read as zero.
  assign tap_near = near_ok_q ? near_rd_q : '0;
  assign tap_far  = far_ok_q  ? far_rd_q  : '0;

  // High-pass recursion. The tap 17 items back is the previous item's tap 16.
  assign hp_d = hp1_q - qrspf_pkg::div32(r2_lp_q) + tap_near - tap_next_q
              + qrspf_pkg::div32(tap_far);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
      r3_valid_q <= 1'b0;
      lp1_q      <= '0;
      lp2_q      <= '0;
      hp1_q      <= '0;
      tap_next_q <= '0;
      wptr_q     <= '0;
      cnt_q      <= '0;
      near_ok_q  <= 1'b0;
      far_ok_q   <= 1'b0;
    end else if (adv_i) begin
      r1_valid_q <= in_valid_i;
      r2_valid_q <= r1_valid_q;
      r3_valid_q <= r2_valid_q;
      near_ok_q  <= cnt_q > LowCntW'(qrspf_pkg::HpTapNear);
      far_ok_q   <= cnt_q > LowCntW'(qrspf_pkg::HpTapFar);
      if (r1_valid_q) begin
        lp1_q  <= lp_d;
        lp2_q  <= lp1_q;
        wptr_q <= wptr_q + 1'b1;
        if (cnt_q != LowCntW'(qrspf_pkg::LowDepth)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (r2_valid_q) begin
        hp1_q      <= hp_d;
        tap_next_q <= tap_near;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r1_fir_q <= fir_d;
      r2_lp_q  <= lp_d;
      r3_lp_q  <= r2_lp_q;
      r3_hp_q  <= hp_d;
    end
  end

  assign stage_o.valid = r3_valid_q;
  assign stage_o.lp    = r3_lp_q;
  assign stage_o.hp    = r3_hp_q;

endmodule

[design/qrspf_energy.sv]
// Derivative, squaring and moving-window integration of the QRS chain.
// The per-sample window contributions live in a circular memory.
// Depends on qrspf_pkg.
module qrspf_energy #(
  parameter int WINDOW = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  qrspf_pkg::bp_out_t bp_i,
  output qrspf_pkg::result_t res_o
);

  localparam int QAw    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QDepth = 1 << QAw;
  localparam int CntW   = $clog2(WINDOW + 1);

  // Reciprocal for exact truncating division of a magnitude up to 2^31.
  localparam int          RecipSh   = 31 + $clog2(WINDOW);
  localparam logic [63:0] RecipNum  = 64'd1 << RecipSh;
  localparam logic [63:0] RecipFull = (RecipNum + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [31:0] Recip     = RecipFull[31:0];

  qrspf_pkg::word_t hist_q [qrspf_pkg::HighTaps];
  qrspf_pkg::word_t dsum_d;

  logic             r4_valid_q;
  qrspf_pkg::word_t r4_lp_q, r4_hp_q, r4_der_q;

  logic             r5_valid_q;
  qrspf_pkg::word_t r5_lp_q, r5_hp_q, r5_der_q, r5_sq_q, sq_d;

  logic             r6_valid_q, r6_neg_q;
  qrspf_pkg::word_t r6_lp_q, r6_hp_q, r6_der_q, r6_sq_q;
  logic [31:0]      mag_d;
  logic [63:0]      r6_prod_q, quot64;
  qrspf_pkg::word_t q_d;

  qrspf_pkg::word_t q_mem [QDepth];
  logic [QAw-1:0]   qwptr_q, old_addr;
  logic [CntW-1:0]  qcnt_q;
  logic [CntW:0]    fill_sum;
  logic             fwd, old_ok_d, old_ok_q;
  qrspf_pkg::word_t old_rd_q, old_val;
  qrspf_pkg::word_t ws_q, ws_d;

  // Five-point derivative; hist_q[k] is the high-pass value k+1 items back.
  assign dsum_d = (bp_i.hp <<< 1) + hist_q[0] - hist_q[2] - (hist_q[3] <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qrspf_pkg::HighTaps; i++) begin
        hist_q[i] <= '0;
      end
    end else if (adv_i && bp_i.valid) begin
      hist_q[0] <= bp_i.hp;
      for (int i = 1; i < qrspf_pkg::HighTaps; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign sq_d  = r4_der_q * r4_der_q;
  assign mag_d = r5_sq_q[qrspf_pkg::DataW-1] ? 32'(-r5_sq_q) : 32'(r5_sq_q);

  // Contribution of this item to the window sum, truncated toward zero.
  assign quot64 = r6_prod_q >> RecipSh;
  assign q_d    = r6_neg_q ? -qrspf_pkg::word_t'(quot64[31:0])
                           :  qrspf_pkg::word_t'(quot64[31:0]);

  // The item moving into R6 reads the contribution of the item WINDOW back.
  // Its own slot is one past the R6 item's slot when that one writes now.
  assign old_addr = qwptr_q + QAw'(r6_valid_q) - QAw'(WINDOW);
  assign fwd      = r6_valid_q && (old_addr == qwptr_q);
  assign fill_sum = (CntW+1)'(qcnt_q) + (CntW+1)'(r6_valid_q);
  assign old_ok_d = fill_sum >= (CntW+1)'(WINDOW);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (fwd) begin
        old_rd_q <= q_d;
      end else begin
        old_rd_q <= q_mem[old_addr];
      end
    end
    if (adv_i && r6_valid_q) begin
      q_mem[qwptr_q] <= q_d;
    end
  end

  assign old_val = old_ok_q ? old_rd_q : '0;
  assign ws_d    = ws_q - old_val + q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r4_valid_q <= 1'b0;
      r5_valid_q <= 1'b0;
      r6_valid_q <= 1'b0;
      old_ok_q   <= 1'b0;
      qwptr_q    <= '0;
      qcnt_q     <= '0;
      ws_q       <= '0;
    end else if (adv_i) begin
      r4_valid_q <= bp_i.valid;
      r5_valid_q <= r4_valid_q;
      r6_valid_q <= r5_valid_q;
      old_ok_q   <= old_ok_d;
      if (r6_valid_q) begin
        ws_q    <= ws_d;
        qwptr_q <= qwptr_q + 1'b1;
        if (qcnt_q != CntW'(WINDOW)) begin
          qcnt_q <= qcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r4_lp_q   <= bp_i.lp;
      r4_hp_q   <= bp_i.hp;
      r4_der_q  <= qrspf_pkg::div8(dsum_d);
      r5_lp_q   <= r4_lp_q;
      r5_hp_q   <= r4_hp_q;
      r5_der_q  <= r4_der_q;
      r5_sq_q   <= sq_d;
      r6_lp_q   <= r5_lp_q;
      r6_hp_q   <= r5_hp_q;
      r6_der_q  <= r5_der_q;
      r6_sq_q   <= r5_sq_q;
      r6_neg_q  <= r5_sq_q[qrspf_pkg::DataW-1];
      r6_prod_q <= {32'b0, mag_d} * {32'b0, Recip};
    end
  end

  assign res_o.valid = r6_valid_q;
  assign res_o.integ = ws_d;
  assign res_o.lp    = r6_lp_q;
  assign res_o.hp    = r6_hp_q;
  assign res_o.der   = r6_der_q;
  assign res_o.sq    = r6_sq_q;

endmodule
